@@ rtl/rc_receiver_frame_decoder_macros.svh @@
// assertion macros used by the port-level checker
`ifndef RC_RECEIVER_FRAME_DECODER_MACROS_SVH
`define RC_RECEIVER_FRAME_DECODER_MACROS_SVH

// property checked at every rising clock edge outside reset
`define RCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the trigger
`define RCFD_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

@@ rtl/rcfd_pkg.sv @@
// shared constants, types and functions of the frame decoder
`timescale 1ns / 1ps
package rcfd_pkg;

  localparam int DATA_BYTES      = 16;
  localparam int POS_W           = 6;
  localparam int FRAME_BYTES_DEF = 18;
  localparam int CH_W            = 11;
  localparam int NUM_CH          = 4;
  localparam int ADDR_W          = 4;

  localparam logic [1:0] REG_RANGE    = 2'd0;
  localparam logic [1:0] REG_DEADBAND = 2'd1;
  localparam logic [1:0] REG_CLAMP    = 2'd2;

  localparam logic [CH_W-1:0] RANGE_RST    = 11'd660;
  localparam logic [CH_W-1:0] DEADBAND_RST = 11'd6;
  localparam logic [CH_W-1:0] CLAMP_RST    = 11'd650;

  typedef struct packed {
    logic [CH_W-1:0] range_limit;
    logic [CH_W-1:0] deadband;
    logic [CH_W-1:0] clamp_limit;
  } cfg_t;

  // raw 11-bit code minus 1024
  function automatic logic signed [CH_W-1:0] ch_value(input logic [CH_W-1:0] raw);
    ch_value = $signed({~raw[CH_W-1], raw[CH_W-2:0]});
  endfunction

  // magnitude of a channel, 1024 fits as unsigned
  function automatic logic [CH_W-1:0] mag_of(input logic signed [CH_W-1:0] v);
    mag_of = v[CH_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ rtl/rcfd_cell.sv @@
// one byte cell of the frame shift chain
`timescale 1ns / 1ps
module rcfd_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

@@ rtl/rcfd_chan.sv @@
// range check, deadband and clamp of one stick channel
`timescale 1ns / 1ps
module rcfd_chan (
  input  logic signed [rcfd_pkg::CH_W-1:0] ch,
  input  logic        [rcfd_pkg::CH_W-1:0] mag,
  input  rcfd_pkg::cfg_t                   cfg,
  output logic signed [rcfd_pkg::CH_W-1:0] shaped,
  output logic                             over
);

  always_comb begin
    over = (mag > cfg.range_limit);
    if (mag <= cfg.deadband) begin
      shaped = '0;
    end else if (mag > cfg.clamp_limit) begin
      shaped = ch[rcfd_pkg::CH_W-1] ? $signed(~cfg.clamp_limit + 1'b1)
                                    : $signed(cfg.clamp_limit);
    end else begin
      shaped = ch;
    end
  end

endmodule

@@ rtl/rc_receiver_frame_decoder.sv @@
// top level of the receiver frame decoder
//
//  port group | direction | handshake          | payload
//  input      | in        | in_valid/in_stall  | rx_byte, frame_start
//  output     | out       | out_valid/out_stall| sticks, switches, mouse, buttons, keys
//  config     | in/out    | psel/penable       | paddr, pwdata, prdata
//
// one byte a cycle enters the 16-cell shift chain unless in_stall holds it; bytes past 16 are counted only
// a frame with both switch fields nonzero leaves through the decode register, then the shaping output register
// in_stall rises only while a decoded frame waits behind a stalled output beat
// synchronous reset clears position, valid flags and registers to defaults
`timescale 1ns / 1ps
module rc_receiver_frame_decoder #(
  parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         rx_byte,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rcfd_pkg::CH_W-1:0]   stick_a,
  output logic signed [rcfd_pkg::CH_W-1:0]   stick_b,
  output logic signed [rcfd_pkg::CH_W-1:0]   stick_c,
  output logic signed [rcfd_pkg::CH_W-1:0]   stick_d,
  output logic [1:0]                         switch_left,
  output logic [1:0]                         switch_right,
  output logic signed [15:0]                 mouse_dx,
  output logic signed [15:0]                 mouse_dy,
  output logic signed [15:0]                 mouse_dz,
  output logic [7:0]                         button_left,
  output logic [7:0]                         button_right,
  output logic [15:0]                        key_mask,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcfd_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int NB = rcfd_pkg::DATA_BYTES;
  localparam int CW = rcfd_pkg::CH_W;
  localparam int NC = rcfd_pkg::NUM_CH;
  localparam logic [rcfd_pkg::POS_W-1:0] LAST_POS = rcfd_pkg::POS_W'(FRAME_BYTES - 1);

  // configuration
  rcfd_pkg::cfg_t cfg;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rcfd_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_limit <= rcfd_pkg::RANGE_RST;
      cfg.deadband    <= rcfd_pkg::DEADBAND_RST;
      cfg.clamp_limit <= rcfd_pkg::CLAMP_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        rcfd_pkg::REG_RANGE:    cfg.range_limit <= pwdata[CW-1:0];
        rcfd_pkg::REG_DEADBAND: cfg.deadband    <= pwdata[CW-1:0];
        rcfd_pkg::REG_CLAMP:    cfg.clamp_limit <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rcfd_pkg::REG_RANGE:    prdata = {21'd0, cfg.range_limit};
      rcfd_pkg::REG_DEADBAND: prdata = {21'd0, cfg.deadband};
      rcfd_pkg::REG_CLAMP:    prdata = {21'd0, cfg.clamp_limit};
      default:                prdata = '0;
    endcase
  end

  // byte position and shift chain
  logic [rcfd_pkg::POS_W-1:0] pos;
  logic [rcfd_pkg::POS_W-1:0] pos_eff;
  logic                       in_acc;
  logic                       shift_en;
  logic                       frame_end;
  logic [7:0]                 cell_q [NB];
  logic [7:0]                 frm    [NB];

  assign in_acc    = in_valid && !in_stall;
  assign pos_eff   = frame_start ? '0 : pos;
  assign shift_en  = in_acc && (pos_eff < rcfd_pkg::POS_W'(NB));
  assign frame_end = in_acc && (pos_eff == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_acc) begin
      pos <= (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NB; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        rcfd_cell u_cell (.clk(clk), .shift(shift_en), .din(rx_byte), .dout(cell_q[gi]));
      end else begin : g_body
        rcfd_cell u_cell (.clk(clk), .shift(shift_en), .din(cell_q[gi-1]), .dout(cell_q[gi]));
      end
    end
  endgenerate

  // frame byte k sits in cell 15-k, or one cell nearer the head when shifting now
  generate
    for (gi = 0; gi < NB; gi++) begin : g_frm
      if (gi == NB-1) begin : g_last
        assign frm[gi] = shift_en ? rx_byte : cell_q[0];
      end else begin : g_rest
        assign frm[gi] = shift_en ? cell_q[NB-2-gi] : cell_q[NB-1-gi];
      end
    end
  endgenerate

  // decode stage
  logic                 a_valid;
  logic signed [CW-1:0] a_ch  [NC];
  logic [CW-1:0]        a_mag [NC];
  logic [1:0]           a_swl;
  logic [1:0]           a_swr;
  logic [15:0]          a_dx, a_dy, a_dz, a_keys;
  logic [7:0]           a_btl, a_btr;
  logic signed [CW-1:0] d_ch  [NC];
  logic [1:0]           d_swl, d_swr;
  logic                 a_load;
  logic                 a_move;
  logic                 b_free;

  assign d_swl = frm[5][7:6];
  assign d_swr = frm[5][5:4];
  assign d_ch[0] = rcfd_pkg::ch_value({frm[1][2:0], frm[0]});
  assign d_ch[1] = rcfd_pkg::ch_value({frm[2][5:0], frm[1][7:3]});
  assign d_ch[2] = rcfd_pkg::ch_value({frm[4][0], frm[3], frm[2][7:6]});
  assign d_ch[3] = rcfd_pkg::ch_value({frm[5][3:0], frm[4][7:1]});

  assign a_load   = frame_end && (d_swl != 2'd0) && (d_swr != 2'd0);
  assign b_free   = !out_valid || !out_stall;
  assign a_move   = a_valid && b_free;
  assign in_stall = a_valid && !b_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      for (int c = 0; c < NC; c++) begin
        a_ch[c]  <= d_ch[c];
        a_mag[c] <= rcfd_pkg::mag_of(d_ch[c]);
      end
      a_swl  <= d_swl;
      a_swr  <= d_swr;
      a_dx   <= {frm[7], frm[6]};
      a_dy   <= {frm[9], frm[8]};
      a_dz   <= {frm[11], frm[10]};
      a_btl  <= frm[12];
      a_btr  <= frm[13];
      a_keys <= {frm[15], frm[14]};
    end
  end

  // shaping stage into the output register
  logic signed [CW-1:0] shaped [NC];
  logic [NC-1:0]        over;
  logic                 any_over;

  generate
    for (gi = 0; gi < NC; gi++) begin : g_chan
      rcfd_chan u_chan (
        .ch(a_ch[gi]), .mag(a_mag[gi]), .cfg(cfg),
        .shaped(shaped[gi]), .over(over[gi])
      );
    end
  endgenerate

  assign any_over = |over;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_free) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      stick_a      <= any_over ? '0 : shaped[0];
      stick_b      <= any_over ? '0 : shaped[1];
      stick_c      <= any_over ? '0 : shaped[2];
      stick_d      <= any_over ? '0 : shaped[3];
      switch_left  <= any_over ? 2'd0 : a_swl;
      switch_right <= any_over ? 2'd0 : a_swr;
      mouse_dx     <= a_dx;
      mouse_dy     <= a_dy;
      mouse_dz     <= a_dz;
      button_left  <= a_btl;
      button_right <= a_btr;
      key_mask     <= a_keys;
    end
  end

endmodule

@@ rtl/rcfd_checker.sv @@
// port-level checker of the frame decoder and its bind
`timescale 1ns / 1ps
`include "rc_receiver_frame_decoder_macros.svh"
module rcfd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [rcfd_pkg::CH_W-1:0] stick_a,
  input logic signed [rcfd_pkg::CH_W-1:0] stick_b,
  input logic signed [rcfd_pkg::CH_W-1:0] stick_c,
  input logic signed [rcfd_pkg::CH_W-1:0] stick_d,
  input logic [1:0]                       switch_left,
  input logic [1:0]                       switch_right,
  input logic signed [15:0]               mouse_dx,
  input logic [15:0]                      key_mask
);

  `RCFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mouse_dx) && $stable(stick_a) && $stable(key_mask), "output beat changed while stalled")

  `RCFD_ASSERT(a_switch_zero, !out_valid || (switch_left != 2'd0 && switch_right != 2'd0) || (switch_left == 2'd0 && switch_right == 2'd0 && stick_a == 0 && stick_b == 0 && stick_c == 0 && stick_d == 0), "zero switch with live sticks")

  `RCFD_ASSERT(a_in_stall_cause, !in_stall || (out_valid && out_stall), "input stalled with output free")

  `RCFD_ASSERT(a_rise_after_byte, !$rose(out_valid) || $past(in_valid && !in_stall, 2), "output beat without a closing byte")

endmodule

bind rc_receiver_frame_decoder rcfd_checker u_rcfd_checker (.*);
